/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, opcodes and the request and response payload types.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int SLOT_W    = 12;
    localparam int CAP_W     = 13;
    localparam int HANDLE_W  = 64;

    localparam logic [SLOT_W-1:0]  FALLBACK_SLOT = '0;
    localparam logic [COUNT_W-1:0] FIRST_FRESH   = COUNT_W'(FALLBACK_SLOT) + COUNT_W'(1);
    localparam logic [CAP_W-1:0]   MIN_CAPACITY  = CAP_W'(2);
    localparam logic [CAP_W-1:0]   RESET_CAP     = CAP_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        OP_REGISTER    = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] view_handle;
        logic [HANDLE_W-1:0] sampler_handle;
        logic [SLOT_W-1:0]   slot_to_free;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic                write_descriptor;
        logic [HANDLE_W-1:0] out_view;
        logic [HANDLE_W-1:0] out_sampler;
        logic                table_full;
        logic                release_dropped;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] data;
    } stack_wr_t;

endpackage

/* rtl/sfs_stack_ram.sv */
// ----------------------------------------------------------------------------
// Free stack memory
// Single-port-write, single-port-read store of freed slots with a registered
// read and forwarding of a write that hits the address being read.
// ----------------------------------------------------------------------------
module sfs_stack_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfs_pkg::stack_wr_t         wr,
    input  logic                       rd_en,
    input  logic [sfs_pkg::ADDR_W-1:0] rd_addr,
    output logic [sfs_pkg::SLOT_W-1:0] rd_data
);
    import sfs_pkg::*;

    logic [SLOT_W-1:0] mem [MAX_SLOTS];
    logic [SLOT_W-1:0] ram_q_reg;
    logic [SLOT_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              fwd_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            ram_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    assign fwd_next = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : ram_q_reg;

endmodule

/* rtl/slot_allocator_free_stack_top.sv */
// ----------------------------------------------------------------------------
// Slot allocator with free stack
// Hands out table slots from a LIFO of released slots or from a fresh counter.
// ----------------------------------------------------------------------------
// Requests arrive on req with req_valid and are taken at an edge where
// req_stall is low; responses leave on rsp with rsp_valid and are taken at an
// edge where rsp_stall is low. Every request gives exactly one response.
// A request is held in an input register while the top of the free stack
// is read from memory, and its response is then registered in the output
// register once that register is free of an untaken response.
// One request is taken every cycle while req_stall is low; the free stack
// memory, with one write and one registered read per cycle, sets that figure.
// The capacity register is written through cfg_wr_en and cfg_wr_data and
// should only be changed while no request is in flight.
// Reset empties the free stack, restarts fresh slots at one and sets the
// capacity to the maximum; no clearing pass is needed.
// While the receiver stalls, the response is held and the request in the
// input register waits, and req_stall rises once that register is occupied.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [sfs_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  sfs_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output sfs_pkg::rsp_t             rsp
);
    import sfs_pkg::*;

    logic [CAP_W-1:0]   cap_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] fresh_reg;
    logic [COUNT_W-1:0] fresh_next;
    logic               a_valid_reg;
    req_t               a_req_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_calc;

    logic [CAP_W-1:0]   eff_cap;
    logic               enabled;
    logic               out_free;
    logic               a_fire;
    logic               accept;
    logic [COUNT_W-1:0] count_upd;
    logic [COUNT_W-1:0] fresh_upd;
    logic [COUNT_W-1:0] rd_ptr;
    stack_wr_t          push;
    stack_wr_t          stack_wr;
    logic [SLOT_W-1:0]  top_slot;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign a_fire    = a_valid_reg && out_free;
    assign req_stall = a_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    assign eff_cap = (cap_reg > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : cap_reg;
    assign enabled = eff_cap >= MIN_CAPACITY;

    always_comb
    begin
        rsp_calc   = '0;
        count_upd  = count_reg;
        fresh_upd  = fresh_reg;
        push.en    = 1'b0;
        push.addr  = count_reg[ADDR_W-1:0];
        push.data  = a_req_reg.slot_to_free;
        case (a_req_reg.opcode)
            OP_REGISTER:
            begin
                if (enabled && (a_req_reg.view_handle != '0)
                    && (a_req_reg.sampler_handle != '0))
                begin
                    if (count_reg != '0)
                    begin
                        count_upd                 = count_reg - COUNT_W'(1);
                        rsp_calc.granted_slot     = top_slot;
                        rsp_calc.write_descriptor = 1'b1;
                    end
                    else if (CAP_W'(fresh_reg) < eff_cap)
                    begin
                        fresh_upd                 = fresh_reg + COUNT_W'(1);
                        rsp_calc.granted_slot     = fresh_reg[SLOT_W-1:0];
                        rsp_calc.write_descriptor = 1'b1;
                    end
                    else
                    begin
                        rsp_calc.table_full = 1'b1;
                    end
                end
                if (rsp_calc.write_descriptor)
                begin
                    rsp_calc.out_view    = a_req_reg.view_handle;
                    rsp_calc.out_sampler = a_req_reg.sampler_handle;
                end
            end
            OP_RELEASE:
            begin
                if (enabled && (a_req_reg.slot_to_free != FALLBACK_SLOT)
                    && (CAP_W'(a_req_reg.slot_to_free) < eff_cap))
                begin
                    if (count_reg < COUNT_W'(MAX_SLOTS))
                    begin
                        push.en   = 1'b1;
                        count_upd = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        rsp_calc.release_dropped = 1'b1;
                    end
                end
            end
            OP_RELEASE_ALL:
            begin
                if (enabled)
                begin
                    count_upd = '0;
                    fresh_upd = FIRST_FRESH;
                end
            end
            default:
            begin
                rsp_calc = '0;
            end
        endcase
    end

    assign count_next  = a_fire ? count_upd : count_reg;
    assign fresh_next  = a_fire ? fresh_upd : fresh_reg;
    assign stack_wr.en   = push.en && a_fire;
    assign stack_wr.addr = push.addr;
    assign stack_wr.data = push.data;
    assign rd_ptr      = count_next - COUNT_W'(1);

    sfs_stack_ram u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (stack_wr),
        .rd_en   (accept),
        .rd_addr (rd_ptr[ADDR_W-1:0]),
        .rd_data (top_slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= RESET_CAP;
            count_reg     <= '0;
            fresh_reg     <= FIRST_FRESH;
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            if (!req_stall)
            begin
                a_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_req_reg <= req;
        end
        if (a_fire)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_SLOTS))
        else $error("Free stack count exceeds the stack depth.");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg >= FIRST_FRESH) && (fresh_reg <= COUNT_W'(MAX_SLOTS)))
        else $error("Fresh slot counter out of range.");

    a_grant_real: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.write_descriptor |-> rsp_reg.granted_slot != FALLBACK_SLOT)
        else $error("Fallback slot handed out as a real slot.");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.table_full |-> !rsp_reg.write_descriptor)
        else $error("Full table reported together with a grant.");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |=> $stable(count_reg) && $stable(fresh_reg))
        else $error("Allocator state changed while the request was held.");
`endif

endmodule
